/* sv/cld_pkg.sv */
`default_nettype none

package cld_pkg;

  // Width of the declared body length.
  localparam int LENGTH_BITS = 31;

  // Length of the "Content-Length: " key.
  localparam int KEY_LEN = 16;
  localparam int KEY_IDX_BITS = $clog2(KEY_LEN);

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;

  // Phase of the length value scan within one header.
  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_VALUE  = 2'd1,
    PH_CR     = 2'd2,
    PH_DONE   = 2'd3
  } value_phase_t;

  // Progress through the CR LF CR LF header terminator.
  typedef enum logic [1:0] {
    TERM_NONE    = 2'd0,
    TERM_CR      = 2'd1,
    TERM_CRLF    = 2'd2,
    TERM_CRLFCR  = 2'd3
  } term_progress_t;

  // Character of the key at the given position.
  function automatic logic [7:0] key_char(input logic [KEY_IDX_BITS-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      default: c = 8'h20; // space
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/content_length_deframer_unit.sv */
// Content-Length deframer: splits a byte stream framed as
// "...Content-Length: <n>\r\n...\r\n\r\n<n body bytes>" into message bodies.
// Input channel: one stream byte per transaction (in_valid / in_stall / in_byte).
// Output channel: one transaction per body byte, carrying the byte, first and
// last marks and the declared body length. Header bytes give no transaction.
// Throughput: one byte per cycle while the receiver keeps out_stall low; the
// header matchers and the decimal accumulator (one shift-add and compare) all
// update in the cycle the byte is accepted.
// Output: a body byte is registered and shows on the output in the cycle after it
// is accepted, and is held in the output register until the receiver takes it.
// When the receiver stalls with a transaction pending, in_stall rises and the
// block holds all state until the output register drains; in the same cycle
// the output is taken a new byte can be accepted.
// Reset (rst_n low, synchronous): header mode, all matchers and the length
// cleared, output register empty.
`default_nettype none

module content_length_deframer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          out_payload_byte,
  output logic                                out_first_of_message,
  output logic                                out_last_of_message,
  output logic [cld_pkg::LENGTH_BITS-1:0]     out_body_length
);

  localparam int LB = cld_pkg::LENGTH_BITS;
  localparam int KB = cld_pkg::KEY_IDX_BITS;

  // Header and body state.
  logic                     in_body_r, in_body_nxt;
  cld_pkg::term_progress_t  term_r, term_nxt;
  logic [KB-1:0]            key_idx_r, key_idx_nxt;
  cld_pkg::value_phase_t    phase_r, phase_nxt;
  logic [LB-1:0]            acc_r, acc_nxt;
  logic                     invalid_r, invalid_nxt;
  logic [LB-1:0]            remaining_r, remaining_nxt;
  logic [LB-1:0]            declared_r, declared_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_byte_r, out_byte_nxt;
  logic                     out_first_r, out_first_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [LB-1:0]            out_len_r, out_len_nxt;

  logic                     accept;
  logic                     is_digit;
  logic [LB+3:0]            acc_times10;
  logic [LB+3:0]            acc_new;
  logic                     overflow;
  logic                     key_hit;
  logic [KB:0]              key_cnt;
  logic                     term_done;
  cld_pkg::value_phase_t    phase_upd;
  logic [LB-1:0]            acc_upd;
  logic                     invalid_upd;
  logic [KB-1:0]            key_idx_upd;
  logic [LB-1:0]            len;

  // Stall the sender only while a body byte waits on a stalled receiver.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Decimal accumulate: acc * 10 + digit, checked against the length range.
  assign is_digit    = (in_byte >= cld_pkg::CHAR_0) && (in_byte <= cld_pkg::CHAR_9);
  assign acc_times10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
  assign acc_new     = acc_times10 + {{(LB+4-4){1'b0}}, in_byte[3:0]};
  assign overflow    = |acc_new[LB+3:LB];

  assign key_hit = (in_byte == cld_pkg::key_char(key_idx_r));
  assign key_cnt = {1'b0, key_idx_r} + {{KB{1'b0}}, 1'b1};

  always_comb begin
    // Key and value scan for this byte.
    phase_upd   = phase_r;
    acc_upd     = acc_r;
    invalid_upd = invalid_r;
    key_idx_upd = key_idx_r;
    unique case (phase_r)
      cld_pkg::PH_SEARCH: begin
        if (key_hit) begin
          if (key_cnt[KB]) begin
            phase_upd   = cld_pkg::PH_VALUE;
            key_idx_upd = '0;
          end else begin
            key_idx_upd = key_cnt[KB-1:0];
          end
        end else if (in_byte == cld_pkg::key_char('0)) begin
          key_idx_upd = {{(KB-1){1'b0}}, 1'b1};
        end else begin
          key_idx_upd = '0;
        end
      end
      cld_pkg::PH_VALUE: begin
        if (in_byte == cld_pkg::CHAR_CR) begin
          phase_upd = cld_pkg::PH_CR;
        end else if (!invalid_r) begin
          if (is_digit && !overflow) begin
            acc_upd = acc_new[LB-1:0];
          end else begin
            invalid_upd = 1'b1;
          end
        end
      end
      cld_pkg::PH_CR: begin
        // A CR not followed by LF belongs to the value and spoils it.
        if (in_byte == cld_pkg::CHAR_LF) begin
          phase_upd = cld_pkg::PH_DONE;
        end else begin
          invalid_upd = 1'b1;
          phase_upd   = (in_byte == cld_pkg::CHAR_CR) ? cld_pkg::PH_CR
                                                       : cld_pkg::PH_VALUE;
        end
      end
      default: ;
    endcase

    // Header terminator tracking.
    term_done = 1'b0;
    term_nxt  = cld_pkg::TERM_NONE;
    if (in_byte == cld_pkg::CHAR_CR) begin
      term_nxt = (term_r == cld_pkg::TERM_CRLF) ? cld_pkg::TERM_CRLFCR
                                                 : cld_pkg::TERM_CR;
    end else if (in_byte == cld_pkg::CHAR_LF) begin
      if (term_r == cld_pkg::TERM_CRLFCR) begin
        term_done = 1'b1;
      end else if (term_r == cld_pkg::TERM_CR) begin
        term_nxt = cld_pkg::TERM_CRLF;
      end
    end

    len = (phase_upd != cld_pkg::PH_SEARCH && !invalid_upd) ? acc_upd : '0;

    // Defaults: hold state, drain the output register when taken.
    in_body_nxt   = in_body_r;
    key_idx_nxt   = key_idx_r;
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    invalid_nxt   = invalid_r;
    remaining_nxt = remaining_r;
    declared_nxt  = declared_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_byte_nxt  = out_byte_r;
    out_first_nxt = out_first_r;
    out_last_nxt  = out_last_r;
    out_len_nxt   = out_len_r;

    if (!accept) begin
      term_nxt = term_r;
    end else if (in_body_r) begin
      // Body byte: emit and count down.
      term_nxt      = term_r;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = in_byte;
      out_first_nxt = (remaining_r == declared_r);
      out_last_nxt  = (remaining_r <= {{(LB-1){1'b0}}, 1'b1});
      out_len_nxt   = declared_r;
      if (remaining_r <= {{(LB-1){1'b0}}, 1'b1}) begin
        remaining_nxt = '0;
        in_body_nxt   = 1'b0;
      end else begin
        remaining_nxt = remaining_r - {{(LB-1){1'b0}}, 1'b1};
      end
    end else if (term_done) begin
      // End of header: clear the scan, enter the body if the length is positive.
      term_nxt    = cld_pkg::TERM_NONE;
      key_idx_nxt = '0;
      phase_nxt   = cld_pkg::PH_SEARCH;
      acc_nxt     = '0;
      invalid_nxt = 1'b0;
      if (len != '0) begin
        in_body_nxt   = 1'b1;
        remaining_nxt = len;
        declared_nxt  = len;
      end
    end else begin
      key_idx_nxt = key_idx_upd;
      phase_nxt   = phase_upd;
      acc_nxt     = acc_upd;
      invalid_nxt = invalid_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r   <= 1'b0;
      term_r      <= cld_pkg::TERM_NONE;
      key_idx_r   <= '0;
      phase_r     <= cld_pkg::PH_SEARCH;
      acc_r       <= '0;
      invalid_r   <= 1'b0;
      remaining_r <= '0;
      declared_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_body_r   <= in_body_nxt;
      term_r      <= term_nxt;
      key_idx_r   <= key_idx_nxt;
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      invalid_r   <= invalid_nxt;
      remaining_r <= remaining_nxt;
      declared_r  <= declared_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload needs no reset.
  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_first_r <= out_first_nxt;
    out_last_r  <= out_last_nxt;
    out_len_r   <= out_len_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_payload_byte     = out_byte_r;
  assign out_first_of_message = out_first_r;
  assign out_last_of_message  = out_last_r;
  assign out_body_length      = out_len_r;

endmodule

`default_nettype wire

/* verif/content_length_deframer_checker.sv */
module content_length_deframer_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic [7:0]                     out_payload_byte,
  input  wire logic                           out_first_of_message,
  input  wire logic                           out_last_of_message,
  input  wire logic [cld_pkg::LENGTH_BITS-1:0] out_body_length,
  output int                                  mismatches,
  output int                                  beats_owed
);
  import cld_pkg::*;

  typedef struct packed {
    logic [7:0]             data;
    logic                   first;
    logic                   last;
    logic [LENGTH_BITS-1:0] length;
  } body_beat_t;

  localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "Content-Length: ";

  logic                   in_body;
  term_progress_t         term_seen;
  logic [4:0]             key_pos;
  value_phase_t           len_phase;
  logic [LENGTH_BITS-1:0] len_acc;
  logic                   len_bad;
  logic [LENGTH_BITS-1:0] body_left;
  logic [LENGTH_BITS-1:0] body_len;
  body_beat_t             beats_due[$];

  initial begin
    mismatches = 0;
    beats_owed = 0;
  end

  function automatic logic [7:0] key_byte(input int idx);
    return KEY_TEXT[8*(KEY_LEN-1-idx) +: 8];
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t: %s", $time, what);
  endtask

  task automatic clear_header_scan();
    term_seen = TERM_NONE;
    key_pos = '0;
    len_phase = PH_SEARCH;
    len_acc = '0;
    len_bad = 1'b0;
  endtask

  // Once the value is bad it stays bad until the header ends.
  task automatic add_len_char(input logic [7:0] c);
    logic [LENGTH_BITS+3:0] grown;
    if (!len_bad) begin
      if (c >= CHAR_0 && c <= CHAR_9) begin
        grown = {4'b0, len_acc} * 10 + (c - CHAR_0);
        if (grown[LENGTH_BITS+3:LENGTH_BITS] != '0) len_bad = 1'b1;
        else len_acc = grown[LENGTH_BITS-1:0];
      end else begin
        len_bad = 1'b1;
      end
    end
  endtask

  task automatic scan_length_value(input logic [7:0] b);
    case (len_phase)
      PH_SEARCH: begin
        if (key_pos < KEY_LEN && b == key_byte(key_pos)) key_pos = key_pos + 5'd1;
        else key_pos = (b == key_byte(0)) ? 5'd1 : 5'd0;
        if (key_pos >= KEY_LEN) begin
          len_phase = PH_VALUE;
          key_pos = '0;
        end
      end
      PH_VALUE: begin
        if (b == CHAR_CR) len_phase = PH_CR;
        else add_len_char(b);
      end
      PH_CR: begin
        if (b == CHAR_LF) begin
          len_phase = PH_DONE;
        end else begin
          // a CR not followed by LF is part of the value
          add_len_char(CHAR_CR);
          if (b != CHAR_CR) begin
            add_len_char(b);
            len_phase = PH_VALUE;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_deframe(input logic [7:0] b);
    logic                   header_end;
    logic [LENGTH_BITS-1:0] found_len;
    header_end = 1'b0;
    if (in_body) begin
      beats_due.push_back('{data: b, first: (body_left == body_len), last: (body_left <= 1),
                            length: body_len});
      if (body_left <= 1) begin
        body_left = '0;
        in_body = 1'b0;
      end else begin
        body_left = body_left - 1'b1;
      end
    end else begin
      scan_length_value(b);
      if (b == CHAR_CR) begin
        term_seen = (term_seen == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
      end else if (b == CHAR_LF) begin
        if (term_seen == TERM_CRLFCR) header_end = 1'b1;
        term_seen = (term_seen == TERM_CR) ? TERM_CRLF : TERM_NONE;
      end else begin
        term_seen = TERM_NONE;
      end
      if (header_end) begin
        found_len = (len_phase != PH_SEARCH && !len_bad) ? len_acc : '0;
        clear_header_scan();
        if (found_len != '0) begin
          in_body = 1'b1;
          body_left = found_len;
          body_len = found_len;
        end
      end
    end
  endtask

  task automatic check_body_beat();
    body_beat_t want;
    if (beats_due.size() == 0) begin
      report_mismatch($sformatf("body byte %02h with no byte due", out_payload_byte));
    end else begin
      want = beats_due.pop_front();
      if (out_payload_byte !== want.data || out_first_of_message !== want.first ||
          out_last_of_message !== want.last || out_body_length !== want.length)
        report_mismatch($sformatf(
          "got byte %02h first %0b last %0b length %0d, want %02h %0b %0b %0d",
          out_payload_byte, out_first_of_message, out_last_of_message, out_body_length,
          want.data, want.first, want.last, want.length));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_body = 1'b0;
      body_left = '0;
      body_len = '0;
      clear_header_scan();
      beats_due.delete();
    end else begin
      if (out_valid && !out_stall) check_body_beat();
      if (in_valid && !in_stall) predict_deframe(in_byte);
    end
    beats_owed = beats_due.size();
  end

endmodule

/* verif/content_length_deframer_unit_test.sv */
module content_length_deframer_unit_test;
  import cld_pkg::*;

  localparam int RANDOM_BYTES = 1500;
  // Longest quiet stretch: a sender gap plus a receiver stall run, many times over.
  localparam int IDLE_LIMIT   = 1000;
  // Body bytes show in the cycle after acceptance; spare drain cycles follow.
  localparam int DRAIN_CYCLES = 4;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             in_byte;
  logic                   out_valid;
  logic                   out_stall;
  logic [7:0]             out_payload_byte;
  logic                   out_first_of_message;
  logic                   out_last_of_message;
  logic [LENGTH_BITS-1:0] out_body_length;

  int    mismatches;
  int    beats_owed;
  int    burst_left = 0;
  int    bytes_sent = 0;
  int    random_start;
  int    idle_cycles = 0;
  int    stall_mode = 0;
  int    stall_mode_left = 0;
  int    stall_tick = 0;
  string length_key = "Content-Length: ";

  content_length_deframer_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_byte              (in_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_payload_byte     (out_payload_byte),
    .out_first_of_message (out_first_of_message),
    .out_last_of_message  (out_last_of_message),
    .out_body_length      (out_body_length)
  );

  // Predict and compare every body transaction beside the block.
  content_length_deframer_checker chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_byte              (in_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_payload_byte     (out_payload_byte),
    .out_first_of_message (out_first_of_message),
    .out_last_of_message  (out_last_of_message),
    .out_body_length      (out_body_length),
    .mismatches           (mismatches),
    .beats_owed           (beats_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Push one byte as an input transaction. The sender works in bursts: when a
  // burst runs out, drop valid for a random gap (sometimes none at all, so
  // long unbroken stretches occur too) and pick a new burst length.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(7, 20);
        default: gap = $urandom_range(1, 6);
      endcase
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    burst_left--;
    bytes_sent++;
    // hold the payload until the block takes it
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Send a header line; an empty line ends the header.
  task automatic send_line(input string s);
    send_text(s);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  task automatic send_body(input int n);
    repeat (n) send_byte($urandom_range(0, 255));
  endtask

  // Unrelated header line with a short printable value.
  task automatic send_filler_line();
    case ($urandom_range(0, 3))
      0:       send_text("Host: ");
      1:       send_text("Content-Type: ");
      2:       send_text("X-Id: ");
      default: send_text("Lengthy: ");
    endcase
    repeat ($urandom_range(0, 6)) send_byte($urandom_range(8'h21, 8'h7E));
    send_line("");
  endtask

  // One message: mostly a well-formed header with a random body, the rest
  // malformed headers, broken sequences and plain noise.
  task automatic send_random_message();
    int    kind;
    int    r;
    int    body_bytes;
    logic  terminated;
    string digits;
    kind = $urandom_range(0, 99);
    terminated = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 70)      body_bytes = $urandom_range(1, 8);
    else if (r < 95) body_bytes = $urandom_range(9, 64);
    else             body_bytes = $urandom_range(65, 300);
    digits = $sformatf("%0d", body_bytes);
    if ($urandom_range(0, 4) == 0) digits = {"00", digits};
    if (kind < 6) begin
      // noise; may leave a header half done for the next message
      repeat ($urandom_range(1, 12)) send_byte($urandom_range(0, 255));
      body_bytes = 0;
      terminated = 1'b0;
    end else begin
      repeat ($urandom_range(0, 2)) send_filler_line();
      if (kind < 70) begin
        send_text(length_key);
        send_line(digits);
      end else if (kind < 74) begin
        send_text(length_key);
        send_line("0");
        body_bytes = 0;
      end else if (kind < 78) begin
        // empty value
        send_line(length_key);
        body_bytes = 0;
      end else if (kind < 84) begin
        // spoil the value with a non-digit, a lone CR among them
        send_text(length_key);
        if ($urandom_range(0, 1) == 0) send_text(digits);
        case ($urandom_range(0, 6))
          0:       send_byte(" ");
          1:       send_byte("+");
          2:       send_byte("-");
          3:       send_byte(CHAR_CR);
          4:       send_byte(CHAR_LF);
          5:       send_byte(8'hFF);
          default: send_byte("a");
        endcase
        send_line(digits);
        body_bytes = 0;
      end else if (kind < 87) begin
        // value beyond the length width
        send_text(length_key);
        if ($urandom_range(0, 1) == 0)
          send_line($sformatf("%0d", 64'd2147483648 + $urandom_range(0, 100000)));
        else
          send_line("99999999999");
        body_bytes = 0;
      end else if (kind < 90) begin
        send_line("Accept: */*");
        body_bytes = 0;
      end else if (kind < 93) begin
        // key match is case-sensitive
        send_text("Content-length: ");
        send_line(digits);
        body_bytes = 0;
      end else if (kind < 95) begin
        // only the first key counts
        send_text(length_key);
        send_line(digits);
        send_filler_line();
        send_text(length_key);
        send_line("7");
      end else if (kind < 98) begin
        // partial key, then the matcher restarts on the real one
        send_text("Content-Len");
        send_text(length_key);
        send_line(digits);
      end else begin
        // header cut short; the next message continues it
        send_text(length_key);
        send_text(digits);
        body_bytes = 0;
        terminated = 1'b0;
      end
      if (terminated) begin
        repeat ($urandom_range(0, 1)) send_filler_line();
        send_line("");
      end
    end
    send_body(body_bytes);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    out_stall = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero and one byte bodies, no key, empty and spoiled values,
    // overflow, wrong case, repeated key, and a key that starts twice.
    send_line("Content-Length: 0");
    send_line("");
    send_line("Content-Length: 1");
    send_line("");
    send_byte(8'hFF);
    send_line("Content-Length: 3");
    send_line("");
    send_byte(8'h00);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_line("X-Tag: 1");
    send_line("");
    send_line("Content-Length: ");
    send_line("");
    send_line("Content-Length: -2");
    send_line("");
    send_line("Content-Length: 1\0152");
    send_line("");
    send_line("Content-Length: 2147483648");
    send_line("");
    send_line("content-length: 2");
    send_line("");
    send_line("Content-Length: 2");
    send_line("Content-Length: 5");
    send_line("");
    send_body(2);
    send_line("CoContent-Length: 0002");
    send_line("Host: a");
    send_line("");
    send_body(2);

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) send_random_message();

    // Largest length last: the block stays in the body for the rest of the run.
    send_line("Content-Length: 2147483647");
    send_line("");
    send_body(5);

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every body byte still due, then a few spare cycles.
    while (beats_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && beats_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver stall pattern: switch between free running, light random,
  // a fixed one-in-three rhythm and heavy random stalling.
  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(16, 160);
    end
    stall_mode_left--;
    stall_tick++;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= (stall_tick % 3 == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

/* filelist.f */
sv/cld_pkg.sv
sv/content_length_deframer_unit.sv
verif/content_length_deframer_checker.sv
verif/content_length_deframer_unit_test.sv
